// ===== rtl/core/triangle_fill_span_rasterizer_top_macros.svh =====
// Assertion helpers shared by the rasterizer RTL.
`ifndef TRIANGLE_FILL_SPAN_RASTERIZER_TOP_MACROS_SVH
`define TRIANGLE_FILL_SPAN_RASTERIZER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define TFSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define TFSR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tfsr_pkg.sv =====
`default_nettype none
package tfsr_pkg;

  localparam int COORD_BITS_DEF        = 11;
  localparam int MAX_SCREEN_HEIGHT_DEF = 64;
  localparam int MAX_SCREEN_WIDTH_DEF  = 256;

  localparam int WIDTH_BITS  = 9;
  localparam int HEIGHT_BITS = 7;
  localparam int ROW_BITS    = 6;
  localparam int COL_BITS    = 8;
  localparam int WORD_BITS   = 16;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 9'd80;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 7'd30;

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SCREEN_HEIGHT = 1'b1;

  localparam int GUARD_BITS = 14;
  localparam logic [GUARD_BITS-1:0] WALK_GUARD = 14'd8192;

  typedef struct packed {
    logic [ROW_BITS-1:0]  row;
    logic [COL_BITS-1:0]  span_start;
    logic [COL_BITS-1:0]  span_end;
    logic                 visible;
    logic [WORD_BITS-1:0] glyph;
    logic [WORD_BITS-1:0] colour;
  } tfsr_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/tfsr_if.sv =====
`default_nettype none
interface tfsr_tri_if #(
  parameter int COORD_BITS = tfsr_pkg::COORD_BITS_DEF
);
  import tfsr_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [COORD_BITS-1:0]  ax;
  logic signed [COORD_BITS-1:0]  ay;
  logic signed [COORD_BITS-1:0]  bx;
  logic signed [COORD_BITS-1:0]  by;
  logic signed [COORD_BITS-1:0]  cx;
  logic signed [COORD_BITS-1:0]  cy;
  logic [WORD_BITS-1:0]          glyph;
  logic [WORD_BITS-1:0]          colour;
  modport source (output valid, ax, ay, bx, by, cx, cy, glyph, colour, input ready);
  modport sink   (input valid, ax, ay, bx, by, cx, cy, glyph, colour, output ready);
endinterface

interface tfsr_span_if;
  import tfsr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ROW_BITS-1:0]  row;
  logic [COL_BITS-1:0]  span_start;
  logic [COL_BITS-1:0]  span_end;
  logic                 visible;
  logic [WORD_BITS-1:0] span_glyph;
  logic [WORD_BITS-1:0] span_colour;
  logic                 last;
  modport source (output valid, row, span_start, span_end, visible, span_glyph,
                  span_colour, last, input ready);
  modport sink   (input valid, row, span_start, span_end, visible, span_glyph,
                  span_colour, last, output ready);
endinterface

interface tfsr_cfg_if;
  import tfsr_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [WIDTH_BITS-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/triangle_fill_span_rasterizer_top.sv =====
// Channel | Dir | Handshake   | Item
// in_i    | in  | valid/ready | one triangle: three vertices, glyph, colour
// out_o   | out | valid/ready | one row span, last set on the final one
// cfg_i   | in  | valid/ready | register write: screen width or height
// One triangle is walked by the single edge-step sequencer: sort, setup, then per row
// the edge steps of each edge, a widen and a push.
// in_i.ready is high only while idle; cfg_i is always ready.
// rst_ni clears control state and loads the screen size 80 by 30.
// With a span already held, a full output register stalls the walk until out_o takes its item.
`default_nettype none
`include "triangle_fill_span_rasterizer_top_macros.svh"
module triangle_fill_span_rasterizer_top #(
  parameter int COORD_BITS        = tfsr_pkg::COORD_BITS_DEF,
  parameter int MAX_SCREEN_HEIGHT = tfsr_pkg::MAX_SCREEN_HEIGHT_DEF,
  parameter int MAX_SCREEN_WIDTH  = tfsr_pkg::MAX_SCREEN_WIDTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  tfsr_tri_if.sink    in_i,
  tfsr_span_if.source out_o,
  tfsr_cfg_if.sink    cfg_i
);
  import tfsr_pkg::*;

  localparam int W  = COORD_BITS + 3;
  localparam int SW = (W > 13) ? W : 13;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SORT   = 4'd1;
  localparam logic [3:0] ST_SETUP  = 4'd2;
  localparam logic [3:0] ST_UOUT   = 4'd3;
  localparam logic [3:0] ST_EDGE0  = 4'd4;
  localparam logic [3:0] ST_EDGE1  = 4'd5;
  localparam logic [3:0] ST_WIDEN  = 4'd6;
  localparam logic [3:0] ST_PUSH   = 4'd7;
  localparam logic [3:0] ST_LSETUP = 4'd8;
  localparam logic [3:0] ST_LOUT   = 4'd9;
  localparam logic [3:0] ST_DONE   = 4'd10;

  logic [3:0] state_q, state_d;
  logic [1:0] sort_q, sort_d;
  logic       lower_q, lower_d;
  logic signed [W-1:0] vx_q [3];
  logic signed [W-1:0] vy_q [3];
  logic signed [W-1:0] vx_d [3];
  logic signed [W-1:0] vy_d [3];
  logic [WORD_BITS-1:0] glyph_q, glyph_d, colour_q, colour_d;
  logic signed [W-1:0] x0_q, x0_d, x1_q, x1_d, err0_q, err0_d, err1_q, err1_d;
  logic signed [W-1:0] maj0_q, maj0_d, maj1_q, maj1_d, min0_q, min0_d, min1_q, min1_d;
  logic signed [W-1:0] i_q, i_d, row_q, row_d, erow_q, erow_d, lo_q, lo_d, hi_q, hi_d;
  logic signed [1:0]   p1_q, p1_d, p2_q, p2_d, s0_q, s0_d, s1_q, s1_d;
  logic c1_q, c1_d, c2_q, c2_d;
  logic [GUARD_BITS-1:0] guard_q, guard_d;
  logic [WIDTH_BITS-1:0]  width_q;
  logic [HEIGHT_BITS-1:0] height_q;
  tfsr_res_t pend_q, pend_d, out_q, out_d;
  logic pend_valid_q, pend_valid_d, out_valid_q, out_valid_d, out_last_q, out_last_d;

  function automatic logic signed [W-1:0] abs_w(input logic signed [W-1:0] v);
    abs_w = (v < 0) ? -v : v;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SCREEN_WIDTH:  width_q  <= cfg_i.data;
        CFG_SCREEN_HEIGHT: height_q <= cfg_i.data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  logic out_free;
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    logic signed [W-1:0]  dx, dy, ext, lo_w, hi_w;
    logic signed [SW-1:0] cw, lo_c, hi_c;
    logic signed [W-1:0]  ch;
    logic                 ge, hit, stop, swp;
    logic [1:0]           ia, ib;
    tfsr_res_t            nres;

    state_d = state_q; sort_d = sort_q; lower_d = lower_q;
    vx_d = vx_q; vy_d = vy_q; glyph_d = glyph_q; colour_d = colour_q;
    x0_d = x0_q; x1_d = x1_q; err0_d = err0_q; err1_d = err1_q;
    maj0_d = maj0_q; maj1_d = maj1_q; min0_d = min0_q; min1_d = min1_q;
    i_d = i_q; row_d = row_q; erow_d = erow_q; lo_d = lo_q; hi_d = hi_q;
    p1_d = p1_q; p2_d = p2_q; s0_d = s0_q; s1_d = s1_q; c1_d = c1_q; c2_d = c2_q;
    guard_d = guard_q;
    pend_d = pend_q; pend_valid_d = pend_valid_q;
    out_d = out_q; out_last_d = out_last_q;
    out_valid_d = (out_valid_q && out_o.ready) ? 1'b0 : out_valid_q;
    dx = '0; dy = '0; ext = '0; ge = 1'b0; hit = 1'b0; stop = 1'b0; swp = 1'b0;
    ia = 2'd0; ib = 2'd1;
    lo_w = '0; hi_w = '0;

    cw = (SW'(width_q) > SW'(MAX_SCREEN_WIDTH)) ? SW'(MAX_SCREEN_WIDTH) : SW'(width_q);
    ch = (W'(height_q) > W'(MAX_SCREEN_HEIGHT)) ? W'(MAX_SCREEN_HEIGHT) : W'(height_q);
    lo_c = (lo_q < 0) ? '0 : SW'(lo_q);
    hi_c = (SW'(hi_q) > cw - SW'(1)) ? cw - SW'(1) : SW'(hi_q);
    nres = '0;
    nres.row = erow_q[ROW_BITS-1:0];
    if (lo_c <= hi_c) begin
      nres.span_start = lo_c[COL_BITS-1:0];
      nres.span_end   = hi_c[COL_BITS-1:0];
      nres.visible    = 1'b1;
      nres.glyph      = glyph_q;
      nres.colour     = colour_q;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          vx_d[0] = W'(in_i.ax); vy_d[0] = W'(in_i.ay);
          vx_d[1] = W'(in_i.bx); vy_d[1] = W'(in_i.by);
          vx_d[2] = W'(in_i.cx); vy_d[2] = W'(in_i.cy);
          glyph_d = in_i.glyph; colour_d = in_i.colour;
          sort_d = 2'd0;
          state_d = ST_SORT;
        end
      end
      ST_SORT: begin
        case (sort_q)
          2'd0:    begin ia = 2'd0; ib = 2'd1; end
          2'd1:    begin ia = 2'd0; ib = 2'd2; end
          default: begin ia = 2'd1; ib = 2'd2; end
        endcase
        swp = vy_q[ia] > vy_q[ib];
        if (swp) begin
          vx_d[ia] = vx_q[ib]; vx_d[ib] = vx_q[ia];
          vy_d[ia] = vy_q[ib]; vy_d[ib] = vy_q[ia];
        end
        sort_d = sort_q + 2'd1;
        if (sort_q == 2'd2) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        x0_d = vx_q[0]; x1_d = vx_q[0]; row_d = vy_q[0]; lower_d = 1'b0;
        dx = vx_q[1] - vx_q[0]; dy = vy_q[1] - vy_q[0];
        s0_d = (dx < 0) ? -2'sd1 : 2'sd1;
        c1_d = dy > abs_w(dx);
        maj0_d = c1_d ? dy : abs_w(dx);
        min0_d = c1_d ? abs_w(dx) : dy;
        err0_d = maj0_d >>> 1;
        dx = vx_q[2] - vx_q[0]; dy = vy_q[2] - vy_q[0];
        s1_d = (dx < 0) ? -2'sd1 : 2'sd1;
        c2_d = dy > abs_w(dx);
        maj1_d = c2_d ? dy : abs_w(dx);
        min1_d = c2_d ? abs_w(dx) : dy;
        err1_d = maj1_d >>> 1;
        i_d = '0;
        state_d = (vy_q[0] != vy_q[1]) ? ST_UOUT : ST_LSETUP;
      end
      ST_UOUT, ST_LOUT: begin
        if ((state_q == ST_UOUT) ? (i_q < maj0_q) : (i_q <= maj0_q)) begin
          p1_d = '0; p2_d = '0;
          lo_d = (x0_q < x1_q) ? x0_q : x1_q;
          hi_d = (x0_q < x1_q) ? x1_q : x0_q;
          state_d = ST_EDGE0;
        end else begin
          state_d = (state_q == ST_UOUT) ? ST_LSETUP : ST_DONE;
        end
      end
      ST_EDGE0: begin
        guard_d = '0;
        if (!(i_q < maj0_q)) begin
          state_d = ST_EDGE1;
        end else begin
          ext = err0_q + min0_q;
          ge = ext >= maj0_q;
          err0_d = ge ? ext - maj0_q : ext;
          if (ge && c1_q) p1_d = s0_q;
          hit = ge && !c1_q;
          if (!lower_q || !(hit || c1_q)) i_d = i_q + W'(1);
          if (hit || c1_q) state_d = ST_EDGE1;
          else x0_d = x0_q + W'(s0_q);
        end
      end
      ST_EDGE1: begin
        stop = (guard_q == WALK_GUARD) || (lower_q && (x1_q == vx_q[2]));
        if (stop) begin
          state_d = ST_WIDEN;
        end else begin
          ext = err1_q + min1_q;
          ge = ext >= maj1_q;
          err1_d = ge ? ext - maj1_q : ext;
          if (ge && c2_q) p2_d = s1_q;
          hit = ge && !c2_q;
          if (hit || c2_q) begin
            state_d = ST_WIDEN;
          end else begin
            x1_d = x1_q + W'(s1_q);
            guard_d = guard_q + GUARD_BITS'(1);
          end
        end
      end
      ST_WIDEN: begin
        lo_w = lo_q; hi_w = hi_q;
        if (x0_q < lo_w) lo_w = x0_q;
        if (x1_q < lo_w) lo_w = x1_q;
        if (x0_q > hi_w) hi_w = x0_q;
        if (x1_q > hi_w) hi_w = x1_q;
        lo_d = lo_w; hi_d = hi_w;
        erow_d = row_q;
        x0_d = x0_q + (c1_q ? W'(0) : W'(s0_q)) + W'(p1_q);
        x1_d = x1_q + (c2_q ? W'(0) : W'(s1_q)) + W'(p2_q);
        row_d = row_q + W'(1);
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (erow_q >= 0 && erow_q < ch) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_d = pend_q; out_last_d = 1'b0; out_valid_d = 1'b1;
            end
            pend_d = nres; pend_valid_d = 1'b1;
            stop = 1'b1;
          end
        end else begin
          stop = 1'b1;
        end
        if (stop) begin
          if (!lower_q) begin
            state_d = (row_q == vy_q[1]) ? ST_LSETUP : ST_UOUT;
          end else if (row_q > vy_q[2]) begin
            state_d = ST_DONE;
          end else begin
            i_d = i_q + W'(1);
            state_d = ST_LOUT;
          end
        end
      end
      ST_LSETUP: begin
        dx = vx_q[2] - vx_q[1]; dy = vy_q[2] - vy_q[1];
        s0_d = (dx < 0) ? -2'sd1 : 2'sd1;
        c1_d = dy > abs_w(dx);
        maj0_d = c1_d ? dy : abs_w(dx);
        min0_d = c1_d ? abs_w(dx) : dy;
        err0_d = maj0_d >>> 1;
        x0_d = vx_q[1];
        i_d = '0;
        lower_d = 1'b1;
        state_d = ST_LOUT;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d = pend_valid_q ? pend_q : '0;
          out_last_d = 1'b1; out_valid_d = 1'b1;
          pend_valid_d = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sort_q <= sort_d; lower_q <= lower_d;
    vx_q <= vx_d; vy_q <= vy_d; glyph_q <= glyph_d; colour_q <= colour_d;
    x0_q <= x0_d; x1_q <= x1_d; err0_q <= err0_d; err1_q <= err1_d;
    maj0_q <= maj0_d; maj1_q <= maj1_d; min0_q <= min0_d; min1_q <= min1_d;
    i_q <= i_d; row_q <= row_d; erow_q <= erow_d; lo_q <= lo_d; hi_q <= hi_d;
    p1_q <= p1_d; p2_q <= p2_d; s0_q <= s0_d; s1_q <= s1_d; c1_q <= c1_d; c2_q <= c2_d;
    guard_q <= guard_d;
    pend_q <= pend_d; out_q <= out_d; out_last_q <= out_last_d;
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.row         = out_q.row;
  assign out_o.span_start  = out_q.span_start;
  assign out_o.span_end    = out_q.span_end;
  assign out_o.visible     = out_q.visible;
  assign out_o.span_glyph  = out_q.glyph;
  assign out_o.span_colour = out_q.colour;
  assign out_o.last        = out_last_q;

  `TFSR_ASSERT_NXT(a_accept_starts_sort, in_i.valid && in_i.ready, state_q == ST_SORT, "accept did not start sort")
  `TFSR_ASSERT_NXT(a_done_drains, (state_q == ST_DONE) && out_free, !pend_valid_q, "held span after last")
  `TFSR_ASSERT_IMP(a_idle_no_pend, in_i.ready, !pend_valid_q, "idle with a held span")
  `TFSR_ASSERT_IMP(a_hidden_zero, out_o.valid && !out_o.visible, out_o.span_glyph == '0 && out_o.span_colour == '0 && out_o.span_start == '0 && out_o.span_end == '0, "hidden span has payload")

endmodule
`default_nettype wire
